/* src/fixed_point_alu_unit_defines.svh */
// Assertion macros shared by the checker.
`ifndef FIXED_POINT_ALU_UNIT_DEFINES_SVH
`define FIXED_POINT_ALU_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FPA_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define FPA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/fpa_pkg.sv */
package fpa_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CmdW   = 4;
  localparam int unsigned ProdW  = 64;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_GT       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_t;

  localparam logic [DataW-1:0] MaxPos = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] MinNeg = 32'h8000_0000;

  // one beat travelling down the cell chain
  typedef struct packed {
    logic             vld;
    logic             is_div;
    logic             neg;
    logic             dbz;
    logic             done;
    logic [DataW-1:0] res;
    logic             cmp;
    logic             sat;
  } ctl_t;

endpackage

/* src/fpa_mul.sv */
module fpa_mul
  import fpa_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic [DataW-1:0] mag_a,
  input  logic [DataW-1:0] mag_b,
  input  logic             neg,
  output logic [DataW-1:0] res,
  output logic             sat
);

  localparam int unsigned HalfW = DataW / 2;

  logic [DataW-1:0]   pll_r, plh_r, phl_r, phh_r;
  logic               neg_r;
  logic [ProdW-1:0]   prod;
  logic [ProdW-1:0]   shf;

  always_ff @(posedge clk) begin
    pll_r <= mag_a[HalfW-1:0] * mag_b[HalfW-1:0];
    plh_r <= mag_a[HalfW-1:0] * mag_b[DataW-1:HalfW];
    phl_r <= mag_a[DataW-1:HalfW] * mag_b[HalfW-1:0];
    phh_r <= mag_a[DataW-1:HalfW] * mag_b[DataW-1:HalfW];
    neg_r <= neg;
  end

  always_comb begin
    prod = {phh_r, pll_r} + ({32'd0, plh_r} << HalfW) + ({32'd0, phl_r} << HalfW);
    shf  = prod >> FRAC_BITS;
    sat  = 1'b0;
    if (neg_r) begin
      if (shf > {32'd0, MinNeg}) begin
        res = MinNeg;
        sat = 1'b1;
      end else begin
        res = DataW'(~shf[DataW-1:0] + 32'd1);
      end
    end else if (shf > {32'd0, MaxPos}) begin
      res = MaxPos;
      sat = 1'b1;
    end else begin
      res = shf[DataW-1:0];
    end
  end

endmodule

/* src/fpa_cell.sv */
module fpa_cell
  import fpa_pkg::*;
#(
  parameter int unsigned QW = 64,
  parameter int unsigned RW = 33,
  parameter int unsigned BIT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_t             ctl_in,
  input  logic [QW-1:0]    num_in,
  input  logic [RW-1:0]    rem_in,
  input  logic [DataW-1:0] den_in,
  output ctl_t             ctl_r,
  output logic [QW-1:0]    num_r,
  output logic [RW-1:0]    rem_r,
  output logic [DataW-1:0] den_r
);

  logic [RW-1:0] trial;
  logic [RW:0]   diff;
  logic [QW-1:0] num_nxt;
  logic [RW-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_in[RW-2:0], num_in[BIT]};
    diff    = {1'b0, trial} - {{(RW+1-DataW){1'b0}}, den_in};
    num_nxt = num_in;
    rem_nxt = rem_in;
    if (ctl_in.is_div) begin
      rem_nxt = trial;
      if (!diff[RW]) begin
        rem_nxt      = diff[RW-1:0];
        num_nxt[BIT] = 1'b1;
      end else begin
        num_nxt[BIT] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r.vld <= ctl_in.vld;
    end
    ctl_r.is_div <= ctl_in.is_div;
    ctl_r.neg    <= ctl_in.neg;
    ctl_r.dbz    <= ctl_in.dbz;
    ctl_r.done   <= ctl_in.done;
    ctl_r.res    <= ctl_in.res;
    ctl_r.cmp    <= ctl_in.cmp;
    ctl_r.sat    <= ctl_in.sat;
    num_r        <= num_nxt;
    rem_r        <= rem_nxt;
    den_r        <= den_in;
  end

endmodule

/* src/fixed_point_alu_unit.sv */
// Channel  | Direction | Ports                                         | Handshake
// input    | in        | in_command, in_operand_a, in_operand_b        | start & !busy
// result   | out       | out_result_value, out_compare_true,
//          |           | out_divide_by_zero, out_saturated             | out_valid
// out_valid rises once a beat has passed the cell chain and the output register, for every command.
// The divide chain (one restoring cell per quotient bit) sets the latency.
// busy is held low: a new beat enters every cycle.
// rst_n clears the valid bits of the chain synchronously.
// The receiver cannot stall; out_valid is high for exactly one cycle per beat.
module fixed_point_alu_unit
  import fpa_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [CmdW-1:0]         in_command,
  input  logic signed [DataW-1:0] in_operand_a,
  input  logic signed [DataW-1:0] in_operand_b,
  output logic                    out_valid,
  output logic signed [DataW-1:0] out_result_value,
  output logic                    out_compare_true,
  output logic                    out_divide_by_zero,
  output logic                    out_saturated
);

  localparam int unsigned QW = DataW + FRAC_BITS;
  localparam int unsigned RW = DataW + 1;
  localparam int unsigned NC = QW;

  ctl_t             ctl   [NC+1];
  logic [QW-1:0]    num   [NC+1];
  logic [RW-1:0]    rem   [NC+1];
  logic [DataW-1:0] den   [NC+1];

  cmd_t             cmd;
  logic [DataW-1:0] ua, ub, mag_a, mag_b;
  logic             neg, sgt, slt;
  logic [DataW-1:0] mul_res;
  logic             mul_sat;
  logic             mul_sel_r;
  ctl_t             fin;
  logic [QW-1:0]    q;
  logic             out_valid_r;
  logic [DataW-1:0] res_r;
  logic             cmp_r, dbz_r, sat_r;
  logic [DataW-1:0] res_nxt;
  logic             sat_nxt;

  assign busy  = 1'b0;
  assign cmd   = cmd_t'(in_command);
  assign ua    = in_operand_a;
  assign ub    = in_operand_b;
  assign mag_a = ua[DataW-1] ? DataW'(~ua + 32'd1) : ua;
  assign mag_b = ub[DataW-1] ? DataW'(~ub + 32'd1) : ub;
  assign neg   = ua[DataW-1] ^ ub[DataW-1];
  assign sgt   = in_operand_a > in_operand_b;
  assign slt   = in_operand_a < in_operand_b;

  always_comb begin
    ctl[0]        = '0;
    ctl[0].vld    = start;
    ctl[0].neg    = neg;
    ctl[0].is_div = (cmd == CMD_DIV) && (ub != '0);
    ctl[0].dbz    = (cmd == CMD_DIV) && (ub == '0);
    ctl[0].done   = !((cmd == CMD_DIV) || (cmd == CMD_MUL));
    case (cmd)
      CMD_ADD:      ctl[0].res = ua + ub;
      CMD_SUB:      ctl[0].res = ua - ub;
      CMD_GT:       ctl[0].cmp = sgt;
      CMD_LT:       ctl[0].cmp = slt;
      CMD_GE:       ctl[0].cmp = !slt;
      CMD_LE:       ctl[0].cmp = !sgt;
      CMD_EQ:       ctl[0].cmp = (ua == ub);
      CMD_NE:       ctl[0].cmp = (ua != ub);
      CMD_MIN:      ctl[0].res = slt ? ua : ub;
      CMD_MAX:      ctl[0].res = sgt ? ua : ub;
      CMD_INC:      ctl[0].res = ua + 32'd1;
      CMD_DEC:      ctl[0].res = ua - 32'd1;
      CMD_FROM_INT: ctl[0].res = ua << FRAC_BITS;
      CMD_TO_INT:   ctl[0].res = DataW'($signed(in_operand_a) >>> FRAC_BITS);
      default:      ctl[0].res = '0;
    endcase
    num[0] = QW'(mag_a) << FRAC_BITS;
    rem[0] = '0;
    den[0] = mag_b;
  end

  for (genvar i = 0; i < NC; i++) begin : g_cell
    fpa_cell #(
      .QW (QW),
      .RW (RW),
      .BIT(QW - 1 - i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_in(ctl[i]),
      .num_in(num[i]),
      .rem_in(rem[i]),
      .den_in(den[i]),
      .ctl_r (ctl[i+1]),
      .num_r (num[i+1]),
      .rem_r (rem[i+1]),
      .den_r (den[i+1])
    );
  end

  // multiplier: enters at the tail of the chain so both paths line up
  fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk  (clk),
    .mag_a(num[NC-1][QW-1:FRAC_BITS]),
    .mag_b(den[NC-1]),
    .neg  (ctl[NC-1].neg),
    .res  (mul_res),
    .sat  (mul_sat)
  );

  always_ff @(posedge clk) begin
    mul_sel_r <= !ctl[NC-1].done && !ctl[NC-1].is_div && !ctl[NC-1].dbz;
  end

  assign fin = ctl[NC];
  assign q   = num[NC];

  always_comb begin
    res_nxt = fin.res;
    sat_nxt = 1'b0;
    if (fin.is_div) begin
      if (fin.neg) begin
        if (q > QW'(MinNeg)) begin
          res_nxt = MinNeg;
          sat_nxt = 1'b1;
        end else begin
          res_nxt = DataW'(~q[DataW-1:0] + 32'd1);
        end
      end else if (q > QW'(MaxPos)) begin
        res_nxt = MaxPos;
        sat_nxt = 1'b1;
      end else begin
        res_nxt = q[DataW-1:0];
      end
    end else if (mul_sel_r) begin
      res_nxt = mul_res;
      sat_nxt = mul_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin.vld;
    end
    res_r <= res_nxt;
    cmp_r <= fin.cmp;
    dbz_r <= fin.dbz;
    sat_r <= sat_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = res_r;
  assign out_compare_true   = cmp_r;
  assign out_divide_by_zero = dbz_r;
  assign out_saturated      = sat_r;

endmodule

/* src/fpa_checker.sv */
`include "fixed_point_alu_unit_defines.svh"

module fpa_checker
  import fpa_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             busy,
  input logic             out_valid,
  input logic [DataW-1:0] out_result_value,
  input logic             out_compare_true,
  input logic             out_divide_by_zero,
  input logic             out_saturated
);

  `FPA_ASSERT_IMPL(a_dbz_zero, clk, rst_n, out_valid && out_divide_by_zero, out_result_value == '0 && !out_saturated && !out_compare_true, "divide by zero beat carries data")
  `FPA_ASSERT_IMPL(a_cmp_zero, clk, rst_n, out_valid && out_compare_true, out_result_value == '0 && !out_saturated, "compare beat carries data")
  `FPA_ASSERT_IMPL(a_sat_clamp, clk, rst_n, out_valid && out_saturated, out_result_value == MaxPos || out_result_value == MinNeg, "saturated beat not clamped")
  `FPA_ASSERT_NEXT(a_no_busy, clk, rst_n, 1'b1, !busy, "busy raised")

endmodule

bind fixed_point_alu_unit fpa_checker u_fpa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_result_value  (out_result_value),
  .out_compare_true  (out_compare_true),
  .out_divide_by_zero(out_divide_by_zero),
  .out_saturated     (out_saturated)
);

/* verif/testbench.sv */
module testbench;
  import fpa_pkg::*;

  localparam int unsigned FracBits = 8;
  localparam int unsigned Latency = 32 + FracBits + 2;
  localparam int unsigned IdleLimit = 20 * Latency + 2000;

  typedef struct {
    logic [DataW-1:0] value;
    logic             cmp;
    logic             dbz;
    logic             sat;
  } alu_res_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [CmdW-1:0]         in_command = '0;
  logic signed [DataW-1:0] in_operand_a = '0;
  logic signed [DataW-1:0] in_operand_b = '0;
  logic                    out_valid;
  logic signed [DataW-1:0] out_result_value;
  logic                    out_compare_true;
  logic                    out_divide_by_zero;
  logic                    out_saturated;

  alu_res_t pending_results[$];
  int       error_count = 0;
  int       items_sent = 0;
  int       results_seen = 0;
  int       idle_cycles = 0;
  int       gap_pct = 0;

  fixed_point_alu_unit #(.FRAC_BITS(FracBits)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_result_value(out_result_value),
    .out_compare_true(out_compare_true), .out_divide_by_zero(out_divide_by_zero),
    .out_saturated(out_saturated)
  );

  always #6 clk = ~clk;

  function automatic logic [DataW-1:0] clamp_signed(logic [63:0] mag, logic neg,
                                                    ref logic sat);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        sat = 1'b1;
        return MinNeg;
      end
      return -mag[31:0];
    end
    if (mag > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return MaxPos;
    end
    return mag[31:0];
  endfunction

  function automatic alu_res_t alu_predict(cmd_t cmd, logic [31:0] a, logic [31:0] b);
    alu_res_t r;
    logic [63:0] ma, mb;
    logic neg;
    ma = a[31] ? {32'd0, -a} : {32'd0, a};
    mb = b[31] ? {32'd0, -b} : {32'd0, b};
    neg = a[31] ^ b[31];
    r = '{value: '0, cmp: 1'b0, dbz: 1'b0, sat: 1'b0};
    case (cmd)
      CMD_ADD: r.value = a + b;
      CMD_SUB: r.value = a - b;
      CMD_MUL: r.value = clamp_signed((ma * mb) >> FracBits, neg, r.sat);
      CMD_DIV: begin
        if (mb == 0) r.dbz = 1'b1;
        else r.value = clamp_signed((ma << FracBits) / mb, neg, r.sat);
      end
      CMD_GT: r.cmp = $signed(a) > $signed(b);
      CMD_LT: r.cmp = $signed(a) < $signed(b);
      CMD_GE: r.cmp = $signed(a) >= $signed(b);
      CMD_LE: r.cmp = $signed(a) <= $signed(b);
      CMD_EQ: r.cmp = a == b;
      CMD_NE: r.cmp = a != b;
      CMD_MIN: r.value = ($signed(a) < $signed(b)) ? a : b;
      CMD_MAX: r.value = ($signed(a) > $signed(b)) ? a : b;
      CMD_INC: r.value = a + 1;
      CMD_DEC: r.value = a - 1;
      CMD_FROM_INT: r.value = a << FracBits;
      default: r.value = $signed(a) >>> FracBits;
    endcase
    return r;
  endfunction

  task automatic send_beat(cmd_t cmd, logic [31:0] a, logic [31:0] b);
    while (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(alu_predict(cmd, a, b));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5, 0))
      0: return $urandom_range(600, 0) - 300;
      1: return {$urandom_range(1, 0) ? 24'hFFFFFF : 24'h0, 8'($urandom)};
      2: return $urandom_range(1, 0) ? MaxPos - $urandom_range(3, 0)
                                     : MinNeg + $urandom_range(3, 0);
      3: return 32'($signed($urandom_range(65535, 0) - 32768)) << $urandom_range(12, 0);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    logic [31:0] edge_vals[6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, MaxPos, MinNeg, 32'h100};
    for (int c = 0; c < 16; c++) send_beat(cmd_t'(c), edge_vals[c % 6], edge_vals[(c + 3) % 6]);
    send_beat(CMD_DIV, 32'h500, 32'h0);
    send_beat(CMD_DIV, MinNeg, 32'h0);
    send_beat(CMD_MUL, MaxPos, MaxPos);
    send_beat(CMD_MUL, MaxPos, MinNeg);
    send_beat(CMD_DIV, MinNeg, 32'h1);
    send_beat(CMD_MIN, 32'h42, 32'h42);
    send_beat(CMD_MAX, MinNeg, MinNeg);
    send_beat(CMD_TO_INT, 32'hFFFF_FF01, 32'h0);
    send_beat(CMD_FROM_INT, 32'h0080_0001, 32'h0);
    drain();
  endtask

  task automatic test_random(int count, int pct);
    gap_pct = pct;
    repeat (count) send_beat(cmd_t'($urandom_range(15, 0)), rand_operand(), rand_operand());
    gap_pct = 0;
    drain();
  endtask

  always @(posedge clk) begin
    alu_res_t exp_r;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected: value %h", $time, out_result_value);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_result_value !== exp_r.value || out_compare_true !== exp_r.cmp ||
            out_divide_by_zero !== exp_r.dbz || out_saturated !== exp_r.sat) begin
          error_count++;
          $display("%0t: expected value %h cmp %b dbz %b sat %b, got %h %b %b %b", $time,
                   exp_r.value, exp_r.cmp, exp_r.dbz, exp_r.sat, out_result_value,
                   out_compare_true, out_divide_by_zero, out_saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(250, 0);
    test_random(250, 69);
    test_random(250, 0);
    test_random(250, 16);
    $display("sent %0d beats over all 16 commands, %0d results checked", items_sent,
             results_seen);
    $display("phases: directed edges, back-to-back and idle-gap random traffic");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
